/* sv/vtgd_pkg.sv */
// ----------------------------------------------------------------------------
// vtgd_pkg
// Shared types, command codes and arithmetic helpers for the vector tile
// geometry decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package vtgd_pkg;

  // Widths of the datapath
  localparam int unsigned CoordW  = 32;
  localparam int unsigned PixelW  = 48;
  localparam int unsigned ScaleW  = 24;
  // Only the low 35 bits of a varint ever matter (32-bit count above a 3-bit id)
  localparam int unsigned VarintW = 35;
  localparam int unsigned ProdW   = CoordW + ScaleW + 1;

  localparam logic [ScaleW-1:0] ScaleReset = 24'd4096;
  localparam logic [3:0]        VarintMaxBytes = 4'd10;
  localparam logic [3:0]        VarintLastIdx  = 4'd9;

  // Command ids
  localparam logic [2:0] CmdMoveTo    = 3'd1;
  localparam logic [2:0] CmdLineTo    = 3'd2;
  localparam logic [2:0] CmdClosePath = 3'd7;

  // What the next complete varint means
  typedef enum logic [2:0] {
    PH_CMD = 3'b001,
    PH_DX  = 3'b010,
    PH_DY  = 3'b100
  } phase_e;

  // Results left over from one accepted beat
  typedef struct packed {
    logic              has_pt;
    logic              has_end;
    logic              start;
    logic              close;
    logic              halted;
    logic [CoordW-1:0] x;
    logic [CoordW-1:0] y;
  } job_t;

  // Bit offset of varint byte n (n is at most 9)
  function automatic logic [5:0] varint_shift(input logic [3:0] n);
    logic [5:0] s;
    s = {2'b00, n} * 6'd7;
    return s;
  endfunction

  // Zigzag decode, low 32 bits
  function automatic logic [CoordW-1:0] zigzag32(input logic [VarintW-1:0] v);
    logic [CoordW-1:0] d;
    d = v[CoordW:1] ^ {CoordW{v[0]}};
    return d;
  endfunction

  // Signed coordinate times unsigned Q8.16 scale, rounded to 8 fraction bits
  function automatic logic [PixelW-1:0] scale_coord(input logic [CoordW-1:0] c,
                                                    input logic [ScaleW-1:0] s);
    logic signed [ProdW-1:0] prod;
    logic signed [ProdW-1:0] rnd;
    prod = ProdW'($signed(c)) * ProdW'($signed({1'b0, s}));
    rnd  = prod + $signed(ProdW'(128));
    return rnd[PixelW+7:8];
  endfunction

endpackage

`default_nettype wire

/* sv/vector_tile_geometry_decoder.sv */
// ----------------------------------------------------------------------------
// vector_tile_geometry_decoder
// Streams the bytes of a packed-varint vector tile geometry blob and emits
// scaled path points plus one end marker per blob.
// ----------------------------------------------------------------------------
//   channel | direction | payload                                   | handshake
//   in      | input     | data_byte, last_byte                      | in_valid/in_ready
//   out     | output    | item_kind, path_start, close_point,       | out_valid/out_ready
//           |           | x_pixel, y_pixel, halted, end_of_run      |
//   cfg     | input     | scale_q16                                 | cfg_valid/cfg_ready
//
// One input beat per cycle while in_ready_o is set. The decoder state updates
// in the accept cycle; the beat's results sit in a job register and leave
// through the output register, one per cycle while not stalled, with the
// coordinate multiply in front of it. A beat with two results (point and end
// marker) holds input until its point has moved out. Reset clears the decoder
// state and sets the scale to 4096; a stalled output stalls the job register.
// ----------------------------------------------------------------------------
`default_nettype none

module vector_tile_geometry_decoder
  import vtgd_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output      logic              in_ready_o,
  input  wire logic [7:0]        data_byte_i,
  input  wire logic              last_byte_i,
  output      logic              out_valid_o,
  input  wire logic              out_ready_i,
  output      logic              item_kind_o,
  output      logic              path_start_o,
  output      logic              close_point_o,
  output      logic [PixelW-1:0] x_pixel_o,
  output      logic [PixelW-1:0] y_pixel_o,
  output      logic              halted_o,
  output      logic              end_of_run_o,
  input  wire logic              cfg_valid_i,
  output      logic              cfg_ready_o,
  input  wire logic [ScaleW-1:0] scale_q16_i
);

  // Decoder state
  logic [ScaleW-1:0]  scale_q;
  logic [VarintW-1:0] acc_q, acc_d;
  logic [3:0]         bytes_q, bytes_d;
  phase_e             phase_q, phase_d;
  logic [31:0]        params_q, params_d;
  logic [VarintW-1:0] pdx_q, pdx_d;
  logic [CoordW-1:0]  cx_q, cx_d, cy_q, cy_d;
  logic [CoordW-1:0]  fx_q, fx_d, fy_q, fy_d;
  logic [CoordW-1:0]  px_q, px_d, py_q, py_d;
  logic               open_q, open_d;
  logic               stop_q, stop_d;

  // Beat decode
  logic [3:0]         n_clip;
  logic [VarintW-1:0] chunk;
  logic [VarintW-1:0] acc_new;
  logic               cmd_fire;
  logic [VarintW-1:0] cmd_val;
  logic [2:0]         cmd_id;
  logic [31:0]        cmd_cnt;
  logic [CoordW-1:0]  cx_new, cy_new;
  job_t               job_new;

  // Job and output registers
  logic  job_valid_q, job_valid_d;
  job_t  job_q, job_d;
  logic  out_free, job_move, job_single, in_fire;

  assign in_fire     = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;

  // Walk one byte through varint assembly, value dispatch and commands
  always_comb begin
    acc_d    = acc_q;
    bytes_d  = bytes_q;
    phase_d  = phase_q;
    params_d = params_q;
    pdx_d    = pdx_q;
    cx_d     = cx_q;
    cy_d     = cy_q;
    fx_d     = fx_q;
    fy_d     = fy_q;
    px_d     = px_q;
    py_d     = py_q;
    open_d   = open_q;
    stop_d   = stop_q;

    n_clip   = (bytes_q > VarintLastIdx) ? VarintLastIdx : bytes_q;
    chunk    = {{(VarintW-7){1'b0}}, data_byte_i[6:0]} << varint_shift(n_clip);
    acc_new  = acc_q | chunk;
    cmd_fire = 1'b0;
    cmd_val  = acc_new;
    cmd_id   = 3'd0;
    cmd_cnt  = 32'd0;
    cx_new   = cx_q + zigzag32(pdx_q);
    cy_new   = cy_q + zigzag32(acc_new);
    job_new  = '0;

    if (!stop_q) begin
      if (!data_byte_i[7]) begin
        acc_d   = '0;
        bytes_d = '0;
        unique case (phase_q)
          PH_DX: begin
            pdx_d   = acc_new;
            phase_d = PH_DY;
          end
          PH_DY: begin
            cx_d = cx_new;
            cy_d = cy_new;
            if (!open_q) begin
              fx_d = cx_new;
              fy_d = cy_new;
            end
            open_d         = 1'b1;
            px_d           = cx_new;
            py_d           = cy_new;
            job_new.has_pt = 1'b1;
            job_new.start  = !open_q;
            job_new.x      = cx_new;
            job_new.y      = cy_new;
            params_d       = params_q - 32'd1;
            phase_d        = (params_d != 32'd0) ? PH_DX : PH_CMD;
          end
          default: cmd_fire = 1'b1;
        endcase
      end else begin
        acc_d   = acc_new;
        bytes_d = n_clip + 4'd1;
        if (bytes_d >= VarintMaxBytes) begin
          stop_d = 1'b1;
        end
      end
    end

    // Read a dangling dx at the end of the blob as a command
    if (last_byte_i && !stop_d && (phase_d == PH_DY)) begin
      cmd_fire = 1'b1;
      cmd_val  = pdx_d;
      phase_d  = PH_CMD;
    end

    // Execute a command
    if (cmd_fire) begin
      cmd_id  = cmd_val[2:0];
      cmd_cnt = cmd_val[VarintW-1:3];
      if (cmd_cnt[31]) begin
        cmd_cnt = 32'd0;
      end
      unique case (cmd_id)
        CmdMoveTo, CmdLineTo: begin
          if (cmd_id == CmdMoveTo) begin
            open_d = 1'b0;
          end
          params_d = cmd_cnt;
          phase_d  = (cmd_cnt != 32'd0) ? PH_DX : PH_CMD;
        end
        CmdClosePath: begin
          if (open_d && ((fx_d != px_d) || (fy_d != py_d))) begin
            job_new.has_pt = 1'b1;
            job_new.close  = 1'b1;
            job_new.x      = fx_d;
            job_new.y      = fy_d;
            px_d           = fx_d;
            py_d           = fy_d;
          end
        end
        default: stop_d = 1'b1;
      endcase
    end

    job_new.has_end = last_byte_i;
    job_new.halted  = stop_d;

    // End of blob: drop all decoder state
    if (last_byte_i) begin
      acc_d    = '0;
      bytes_d  = '0;
      phase_d  = PH_CMD;
      params_d = '0;
      pdx_d    = '0;
      cx_d     = '0;
      cy_d     = '0;
      fx_d     = '0;
      fy_d     = '0;
      px_d     = '0;
      py_d     = '0;
      open_d   = 1'b0;
      stop_d   = 1'b0;
    end
  end

  // Advance decoder state on each accepted beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q    <= '0;
      bytes_q  <= '0;
      phase_q  <= PH_CMD;
      params_q <= '0;
      pdx_q    <= '0;
      cx_q     <= '0;
      cy_q     <= '0;
      fx_q     <= '0;
      fy_q     <= '0;
      px_q     <= '0;
      py_q     <= '0;
      open_q   <= 1'b0;
      stop_q   <= 1'b0;
    end else if (in_fire) begin
      acc_q    <= acc_d;
      bytes_q  <= bytes_d;
      phase_q  <= phase_d;
      params_q <= params_d;
      pdx_q    <= pdx_d;
      cx_q     <= cx_d;
      cy_q     <= cy_d;
      fx_q     <= fx_d;
      fy_q     <= fy_d;
      px_q     <= px_d;
      py_q     <= py_d;
      open_q   <= open_d;
      stop_q   <= stop_d;
    end
  end

  // Hold the scale register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_q <= ScaleReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      scale_q <= scale_q16_i;
    end
  end

  // Drain the job register into the output register, point before end marker
  assign out_free   = !out_valid_o || out_ready_i;
  assign job_move   = job_valid_q && out_free;
  assign job_single = !(job_q.has_pt && job_q.has_end);
  assign in_ready_o = !job_valid_q || (out_free && job_single);

  always_comb begin
    job_d       = job_q;
    job_valid_d = job_valid_q;
    if (job_move) begin
      job_d.has_pt = 1'b0;
      job_valid_d  = !job_single;
    end
    if (in_fire) begin
      job_d       = job_new;
      job_valid_d = job_new.has_pt || job_new.has_end;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      job_valid_q <= 1'b0;
      out_valid_o <= 1'b0;
    end else begin
      job_valid_q <= job_valid_d;
      if (job_move) begin
        out_valid_o <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_o <= 1'b0;
      end
    end
  end

  // Load result payload; scale the coordinates on the way out
  always_ff @(posedge clk_i) begin
    job_q <= job_d;
    if (job_move) begin
      if (job_q.has_pt) begin
        item_kind_o   <= 1'b0;
        path_start_o  <= job_q.start;
        close_point_o <= job_q.close;
        x_pixel_o     <= scale_coord(job_q.x, scale_q);
        y_pixel_o     <= scale_coord(job_q.y, scale_q);
        halted_o      <= 1'b0;
        end_of_run_o  <= !job_q.has_end;
      end else begin
        item_kind_o   <= 1'b1;
        path_start_o  <= 1'b0;
        close_point_o <= 1'b0;
        x_pixel_o     <= '0;
        y_pixel_o     <= '0;
        halted_o      <= job_q.halted;
        end_of_run_o  <= 1'b1;
      end
    end
  end

  // Checks
  a_no_accept_over_two: assert property (@(posedge clk_i) disable iff (!rst_ni)
      in_fire |-> !(job_valid_q && job_q.has_pt && job_q.has_end))
    else $error("beat accepted while job still holds two results");

  a_job_not_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
      job_valid_q |-> (job_q.has_pt || job_q.has_end))
    else $error("valid job without any result");

  a_end_item_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
      (out_valid_o && item_kind_o) |->
        (end_of_run_o && !path_start_o && !close_point_o &&
         (x_pixel_o == '0) && (y_pixel_o == '0)))
    else $error("end item carries point data");

  a_overlong_stops: assert property (@(posedge clk_i) disable iff (!rst_ni)
      (bytes_q < VarintMaxBytes) || stop_q)
    else $error("varint byte count reached limit without halting");

  a_phase_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
      $onehot(phase_q))
    else $error("phase register not one-hot");

endmodule

`default_nettype wire
